/* rtl/fatcr_pkg.sv */
`default_nettype none
package fatcr_pkg;

  // Fixed geometry of the scheme.
  localparam logic [15:0] CHAIN_END = 16'hFFF8;
  localparam logic [15:0] CHAIN_OOB = 16'hFFFF;
  localparam int SKIP_W = 23;
  localparam int OFF_W  = 15;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_PART_START  = 3'd0;
  localparam logic [2:0] REG_RESERVED    = 3'd1;
  localparam logic [2:0] REG_FAT_COPIES  = 3'd2;
  localparam logic [2:0] REG_SECT_PER_FAT = 3'd3;
  localparam logic [2:0] REG_ROOT_ENTRIES = 3'd4;
  localparam logic [2:0] REG_CLUSTER_SECT = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PAST_END  = 2'd1;
  localparam logic [1:0] ST_CHAIN_END = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  typedef struct packed {
    logic [31:0] part_start;
    logic [15:0] reserved;
    logic [2:0]  fat_copies;
    logic [15:0] sect_per_fat;
    logic [15:0] root_entries;
    logic [6:0]  cluster_sect;
  } cfg_t;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_PAST  = 2'd1,
    K_READ  = 2'd2
  } kind_t;

  // One classified transaction passed from the front to the back.
  typedef struct packed {
    kind_t              kind;
    logic [15:0]        cl;
    logic [15:0]        val;
    logic [31:0]        size;
    logic [SKIP_W-1:0]  skip;
    logic [OFF_W-1:0]   off;
  } entry_t;

  // Sectors per cluster clamped to 1..64.
  function automatic logic [6:0] eff_sectors(input logic [6:0] cs);
    logic [6:0] r;
    r = cs;
    if (cs == 7'd0) r = 7'd1;
    if (cs > 7'd64) r = 7'd64;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/fat16_cluster_chain_reader.sv */
`default_nettype none
// Table write: the entry passes the front's register and the queue, then is stored; no result.
// Read: the front divides the start offset, hands the entry off through the queue, then the back
// reads and checks the table once per skipped cluster and computes and issues each read command.
// A read past the end of the file skips the division and gives a single past-end result.
// The front takes no new transaction until the last one is queued; the back runs one walk at a time.
// Synchronous reset clears control and restores configuration defaults; the table is undefined.
module fat16_cluster_chain_reader import fatcr_pkg::*; #(
  parameter int FAT_ENTRIES  = 65536,
  parameter int MAX_COMMANDS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [15:0] fat_index,
  input  wire logic [15:0] fat_value,
  input  wire logic [15:0] first_cluster,
  input  wire logic [31:0] file_length,
  input  wire logic [31:0] start_byte,
  input  wire logic [31:0] request_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      sector_address,
  output logic [14:0]      cluster_offset,
  output logic [15:0]      byte_count,
  output logic             last,
  output logic [31:0]      total_bytes,
  output logic [1:0]       status
);

  cfg_t cfg;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  entry_t q_in;
  entry_t q_out;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.part_start   <= 32'd0;
      cfg.reserved     <= 16'd1;
      cfg.fat_copies   <= 3'd2;
      cfg.sect_per_fat <= 16'd1;
      cfg.root_entries <= 16'd512;
      cfg.cluster_sect <= 7'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PART_START:   cfg.part_start   <= cfg_data;
        REG_RESERVED:     cfg.reserved     <= cfg_data[15:0];
        REG_FAT_COPIES:   cfg.fat_copies   <= cfg_data[2:0];
        REG_SECT_PER_FAT: cfg.sect_per_fat <= cfg_data[15:0];
        REG_ROOT_ENTRIES: cfg.root_entries <= cfg_data[15:0];
        REG_CLUSTER_SECT: cfg.cluster_sect <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  fatcr_front u_front (
    .clk, .rst, .cfg, .in_valid, .in_stall, .func, .fat_index, .fat_value,
    .first_cluster, .file_length, .start_byte, .request_bytes,
    .q_push, .q_data(q_in), .q_full
  );

  fatcr_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  fatcr_back #(
    .FAT_ENTRIES(FAT_ENTRIES),
    .MAX_COMMANDS(MAX_COMMANDS)
  ) u_back (
    .clk, .rst, .cfg, .q_data(q_out), .q_empty, .q_pop,
    .out_valid, .out_stall, .sector_address, .cluster_offset, .byte_count,
    .last, .total_bytes, .status
  );

endmodule
`default_nettype wire

/* rtl/fatcr_front.sv */
`default_nettype none
module fatcr_front import fatcr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [15:0] fat_index,
  input  wire logic [15:0] fat_value,
  input  wire logic [15:0] first_cluster,
  input  wire logic [31:0] file_length,
  input  wire logic [31:0] start_byte,
  input  wire logic [31:0] request_bytes,
  output logic             q_push,
  output entry_t           q_data,
  input  wire logic        q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state;
  entry_t entry;
  logic [6:0] rem;
  logic [SKIP_W-1:0] quo;
  logic [4:0] div_cnt;
  logic [8:0] low_bits;
  logic [6:0] eff;
  logic [7:0] trial;
  logic trial_ge;
  logic [31:0] tail;

  assign eff = eff_sectors(cfg.cluster_sect);
  assign in_stall = (state != F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_data = entry;
  assign tail = file_length - start_byte;

  // One quotient bit per cycle of (start_byte / 512) / sectors per cluster.
  assign trial = {rem, quo[SKIP_W-1]};
  assign trial_ge = (trial >= {1'b0, eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= (func && start_byte < file_length) ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          if (div_cnt == 5'd0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Classify the transaction and run the divider.
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          entry.cl   <= func ? first_cluster : fat_index;
          entry.val  <= fat_value;
          entry.size <= (request_bytes < tail) ? request_bytes : tail;
          entry.skip <= '0;
          entry.off  <= '0;
          rem        <= '0;
          quo        <= start_byte[31:9];
          low_bits   <= start_byte[8:0];
          div_cnt    <= 5'(SKIP_W - 1);
          if (!func) begin
            entry.kind <= K_WRITE;
          end else if (start_byte >= file_length) begin
            entry.kind <= K_PAST;
          end else begin
            entry.kind <= K_READ;
          end
        end
      end
      F_DIV: begin
        rem <= trial_ge ? 7'(trial - {1'b0, eff}) : trial[6:0];
        quo <= {quo[SKIP_W-2:0], trial_ge};
        div_cnt <= div_cnt - 5'd1;
        if (div_cnt == 5'd0) begin
          entry.skip <= {quo[SKIP_W-2:0], trial_ge};
          entry.off  <= {(trial_ge ? 6'(trial - {1'b0, eff}) : trial[5:0]), low_bits};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/fatcr_queue.sv */
`default_nettype none
module fatcr_queue import fatcr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output entry_t      pop_data,
  output logic        empty
);

  localparam int DEPTH = 2;

  entry_t slots [DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(DEPTH));
  assign empty = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/fatcr_back.sv */
`default_nettype none
module fatcr_back import fatcr_pkg::*; #(
  parameter int FAT_ENTRIES  = 65536,
  parameter int MAX_COMMANDS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire entry_t      q_data,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      sector_address,
  output logic [14:0]      cluster_offset,
  output logic [15:0]      byte_count,
  output logic             last,
  output logic [31:0]      total_bytes,
  output logic [1:0]       status
);

  localparam int IW = $clog2(FAT_ENTRIES);
  localparam int NW = $clog2(MAX_COMMANDS + 1);
  localparam logic [16:0] ENTRIES_L = 17'(FAT_ENTRIES);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_SKRD  = 5'b00010,
    B_SKCHK = 5'b00100,
    B_CMD   = 5'b01000,
    B_NXT   = 5'b10000
  } bstate_t;

  bstate_t state;
  logic [15:0] alloc_table [FAT_ENTRIES];
  logic [15:0] rd_data;
  logic rd_oob;
  logic rd_en;
  logic [15:0] cl;
  logic [SKIP_W-1:0] skip;
  logic [OFF_W-1:0] off;
  logic [31:0] size;
  logic [31:0] remaining;
  logic [15:0] take;
  logic [31:0] base_adj;
  logic [31:0] sec;
  logic [NW-1:0] cmd_count;
  logic [6:0] eff;
  logic [15:0] cbytes;
  logic [15:0] avail;
  logic [15:0] nx;
  logic [31:0] rem_n;
  logic [NW-1:0] count_n;
  logic out_free;
  logic out_load;
  logic cmd_end;
  logic cmd_trunc;
  logic [18:0] fat_secs;
  logic [12:0] root_secs;
  logic [22:0] cl_prod;

  assign eff = eff_sectors(cfg.cluster_sect);
  assign cbytes = {eff, 9'd0};
  assign avail = cbytes - 16'(off);
  assign nx = rd_oob ? CHAIN_OOB : rd_data;
  assign rem_n = remaining - 32'(take);
  assign count_n = cmd_count + NW'(1);
  assign out_free = !out_valid || !out_stall;
  assign fat_secs = cfg.fat_copies * cfg.sect_per_fat;
  assign root_secs = 13'((17'(cfg.root_entries) + 17'd15) >> 4);
  assign cl_prod = cl * eff;
  assign rd_en = (state == B_SKRD) || (state == B_CMD);

  assign q_pop = (state == B_IDLE) && !q_empty && ((q_data.kind != K_PAST) || out_free);

  // A command is final when the bytes run out or the chain ends; otherwise the limit truncates.
  assign cmd_end = (rem_n == '0) || (nx >= CHAIN_END);
  assign cmd_trunc = !cmd_end && (count_n >= NW'(MAX_COMMANDS));
  assign out_load = (q_pop && q_data.kind == K_PAST)
                    || (state == B_SKCHK && nx >= CHAIN_END && out_free)
                    || (state == B_NXT && out_free);

  // Table writes in order with reads.
  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind == K_WRITE && {1'b0, q_data.cl} < ENTRIES_L) begin
      alloc_table[q_data.cl[IW-1:0]] <= q_data.val;
    end
  end

  // Registered chain lookup.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= alloc_table[cl[IW-1:0]];
      rd_oob  <= ({1'b0, cl} >= ENTRIES_L);
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Chain walk sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cmd_count <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_pop && q_data.kind == K_READ) begin
            cmd_count <= '0;
            state <= (q_data.skip == '0) ? B_CMD : B_SKRD;
          end
        end
        B_SKRD: state <= B_SKCHK;
        B_SKCHK: begin
          if (nx >= CHAIN_END) begin
            if (out_free) begin
              state <= B_IDLE;
            end
          end else begin
            state <= (skip == SKIP_W'(1)) ? B_CMD : B_SKRD;
          end
        end
        B_CMD: state <= B_NXT;
        B_NXT: begin
          if (out_free) begin
            cmd_count <= count_n;
            state <= (cmd_end || cmd_trunc) ? B_IDLE : B_CMD;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Walk registers and the output register.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_pop) begin
          cl        <= q_data.cl;
          skip      <= q_data.skip;
          off       <= q_data.off;
          size      <= q_data.size;
          remaining <= q_data.size;
          base_adj  <= cfg.part_start + 32'(cfg.reserved) + 32'(fat_secs)
                       + 32'(root_secs) - 32'({eff, 1'b0});
          if (q_data.kind == K_PAST) begin
            sector_address <= '0;
            cluster_offset <= '0;
            byte_count     <= '0;
            last           <= 1'b1;
            total_bytes    <= '0;
            status         <= ST_PAST_END;
          end
        end
      end
      B_SKCHK: begin
        if (nx >= CHAIN_END) begin
          if (out_free) begin
            sector_address <= '0;
            cluster_offset <= '0;
            byte_count     <= '0;
            last           <= 1'b1;
            total_bytes    <= '0;
            status         <= ST_CHAIN_END;
          end
        end else begin
          cl   <= nx;
          skip <= skip - SKIP_W'(1);
        end
      end
      B_CMD: begin
        sec  <= base_adj + 32'(cl_prod);
        take <= (32'(avail) > remaining) ? remaining[15:0] : avail;
      end
      B_NXT: begin
        if (out_free) begin
          sector_address <= sec;
          cluster_offset <= off;
          byte_count     <= take;
          last           <= cmd_end || cmd_trunc;
          total_bytes    <= (cmd_end || cmd_trunc) ? size - rem_n : '0;
          status         <= cmd_trunc ? ST_TRUNC : ST_OK;
          remaining      <= rem_n;
          off            <= '0;
          cl             <= nx;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= NW'(MAX_COMMANDS))
    else $error("command count above limit");
  a_take_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_NXT |-> (take <= cbytes && 32'(take) <= remaining))
    else $error("byte count exceeds cluster or remainder");
  a_remain_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_NXT |-> remaining <= size)
    else $error("remaining bytes exceed clipped size");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import fatcr_pkg::*;

  // One read command as seen on the result channel.
  typedef struct {
    logic [31:0] sec;
    logic [14:0] off;
    logic [15:0] cnt;
    logic        lst;
    logic [31:0] tot;
    logic [1:0]  st;
  } cmd_t;

  // One line of the directed stimulus table.
  typedef struct {
    bit          func;
    logic [15:0] idx;
    logic [15:0] val;
    logic [15:0] cl;
    logic [31:0] flen;
    logic [31:0] start;
    logic [31:0] req;
    bit          typed;
    cmd_t        exp;
  } row_t;

  localparam int WALK_CAP = 300;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic func;
  logic [15:0] fat_index, fat_value, first_cluster;
  logic [31:0] file_length, start_byte, request_bytes;
  logic out_valid, out_stall;
  logic [31:0] sector_address;
  logic [14:0] cluster_offset;
  logic [15:0] byte_count;
  logic last;
  logic [31:0] total_bytes;
  logic [1:0] status;

  fat16_cluster_chain_reader dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .fat_index(fat_index),
    .fat_value(fat_value), .first_cluster(first_cluster), .file_length(file_length),
    .start_byte(start_byte), .request_bytes(request_bytes),
    .out_valid(out_valid), .out_stall(out_stall), .sector_address(sector_address),
    .cluster_offset(cluster_offset), .byte_count(byte_count), .last(last),
    .total_bytes(total_bytes), .status(status)
  );

  // Shadow of the volume geometry registers.
  logic [31:0] geo_part;
  logic [15:0] geo_res;
  logic [2:0]  geo_copies;
  logic [15:0] geo_spf;
  logic [15:0] geo_root;
  logic [6:0]  geo_cs;

  // Shadow allocation table; only written entries exist.
  logic [15:0] fat_mem[int];

  cmd_t walk_plan[$];
  cmd_t expected_cmds[$];
  int   mismatches = 0;
  bit   calm = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] clamp_sectors();
    logic [31:0] s;
    s = {25'd0, geo_cs};
    if (s == 32'd0) s = 32'd1;
    if (s > 32'd64) s = 32'd64;
    return s;
  endfunction

  function automatic logic [31:0] cluster_sector(input logic [31:0] c);
    logic [31:0] root_secs;
    root_secs = ({16'd0, geo_root} * 32'd32 + 32'd511) / 32'd512;
    return geo_part + {16'd0, geo_res} + {29'd0, geo_copies} * {16'd0, geo_spf}
      + root_secs + (c - 32'd2) * clamp_sectors();
  endfunction

  function automatic cmd_t make_cmd(input logic [31:0] sec, input logic [14:0] off,
                                    input logic [15:0] cnt, input logic lst,
                                    input logic [31:0] tot, input logic [1:0] st);
    cmd_t r;
    r.sec = sec; r.off = off; r.cnt = cnt; r.lst = lst; r.tot = tot; r.st = st;
    return r;
  endfunction

  // Walk the chain for one read request and fill walk_plan. Stops early when an
  // entry that was never written would be read (miss) or the walk runs too long.
  task automatic build_walk(input logic [15:0] c0, input logic [31:0] flen,
                            input logic [31:0] start, input logic [31:0] req,
                            output int miss, output bit too_long);
    logic [31:0] cl, size, cb, skip, off, remaining, take, nx;
    int n, steps;
    miss = -1;
    too_long = 0;
    walk_plan.delete();
    if (start >= flen) begin
      walk_plan.push_back(make_cmd(0, 0, 0, 1'b1, 0, ST_PAST_END));
      return;
    end
    size = flen - start;
    if (req < size) size = req;
    cb = clamp_sectors() * 32'd512;
    skip = start / cb;
    off = start % cb;
    cl = {16'd0, c0};
    steps = 0;
    // Skip the clusters in front of the start offset.
    for (logic [31:0] i = 0; i < skip; i++) begin
      if (!fat_mem.exists(cl)) begin
        miss = cl;
        return;
      end
      steps++;
      if (steps > WALK_CAP) begin
        too_long = 1;
        return;
      end
      nx = {16'd0, fat_mem[cl]};
      if (nx >= {16'd0, CHAIN_END}) begin
        walk_plan.delete();
        walk_plan.push_back(make_cmd(0, 0, 0, 1'b1, 0, ST_CHAIN_END));
        return;
      end
      cl = nx;
    end
    if (size == 0) begin
      walk_plan.push_back(make_cmd(cluster_sector(cl), off[14:0], 0, 1'b1, 0, ST_OK));
      return;
    end
    // One command per cluster touched.
    remaining = size;
    n = 0;
    forever begin
      take = cb - off;
      if (take > remaining) take = remaining;
      walk_plan.push_back(make_cmd(cluster_sector(cl), off[14:0], take[15:0], 1'b0, 0, ST_OK));
      n++;
      remaining -= take;
      off = 0;
      if (!fat_mem.exists(cl)) begin
        miss = cl;
        return;
      end
      nx = {16'd0, fat_mem[cl]};
      if (remaining == 0 || nx >= {16'd0, CHAIN_END}) begin
        walk_plan[walk_plan.size()-1].lst = 1'b1;
        walk_plan[walk_plan.size()-1].tot = size - remaining;
        return;
      end
      if (n >= 64) begin
        walk_plan[walk_plan.size()-1].lst = 1'b1;
        walk_plan[walk_plan.size()-1].tot = size - remaining;
        walk_plan[walk_plan.size()-1].st = ST_TRUNC;
        return;
      end
      cl = nx;
    end
  endtask

  // Drive one input transaction, with an optional idle burst in front of it.
  task automatic send_item(input bit f, input logic [15:0] idx, input logic [15:0] val,
                           input logic [15:0] cl, input logic [31:0] flen,
                           input logic [31:0] start, input logic [31:0] req);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    func = f; fat_index = idx; fat_value = val; first_cluster = cl;
    file_length = flen; start_byte = start; request_bytes = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f == 1'b0) fat_mem[idx] = val;
    else foreach (walk_plan[i]) expected_cmds.push_back(walk_plan[i]);
  endtask

  function automatic logic [15:0] pick_link();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CHAIN_END + 16'($urandom_range(0, 7));
    if (r < 85) return 16'($urandom_range(2, 40));
    return 16'($urandom);
  endfunction

  // Issue a read, first writing any table entry the walk would need. Returns 0
  // when the walk is too long to be worth running.
  task automatic issue_read(input logic [15:0] cl, input logic [31:0] flen,
                            input logic [31:0] start, input logic [31:0] req,
                            input bit typed, input cmd_t exp, output bit ok);
    int miss;
    bit too_long;
    ok = 0;
    forever begin
      build_walk(cl, flen, start, req, miss, too_long);
      if (too_long) return;
      if (miss < 0) break;
      send_item(1'b0, 16'(miss), pick_link(), 16'($urandom), $urandom, $urandom, $urandom);
    end
    if (typed) begin
      walk_plan.delete();
      walk_plan.push_back(exp);
    end
    send_item(1'b1, 16'($urandom), 16'($urandom), cl, flen, start, req);
    ok = 1;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PART_START:   geo_part = data;
      REG_RESERVED:     geo_res = data[15:0];
      REG_FAT_COPIES:   geo_copies = data[2:0];
      REG_SECT_PER_FAT: geo_spf = data[15:0];
      REG_ROOT_ENTRIES: geo_root = data[15:0];
      REG_CLUSTER_SECT: geo_cs = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let the block drain: all results in, then time for trailing table writes.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic row_t wr_row(input logic [15:0] idx, input logic [15:0] val);
    row_t r;
    r = '{default: 0};
    r.func = 1'b0; r.idx = idx; r.val = val;
    return r;
  endfunction

  function automatic row_t rd_row(input logic [15:0] cl, input logic [31:0] flen,
                                  input logic [31:0] start, input logic [31:0] req,
                                  input bit typed, input cmd_t exp);
    row_t r;
    r = '{default: 0};
    r.func = 1'b1; r.cl = cl; r.flen = flen; r.start = start; r.req = req;
    r.typed = typed; r.exp = exp;
    return r;
  endfunction

  // Result channel stall in random bursts.
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) out_stall = 1'b0;
      else if (hold > 0) hold--;
      else if ($urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        hold = $urandom_range(0, 8);
      end else out_stall = 1'b0;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    cmd_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: sec=%h", sector_address);
      end else begin
        e = expected_cmds.pop_front();
        if (sector_address !== e.sec || cluster_offset !== e.off || byte_count !== e.cnt ||
            last !== e.lst || total_bytes !== e.tot || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp sec=%h off=%0d cnt=%0d last=%b tot=%0d st=%0d,",
                      " got sec=%h off=%0d cnt=%0d last=%b tot=%0d st=%0d"},
                     e.sec, e.off, e.cnt, e.lst, e.tot, e.st, sector_address,
                     cluster_offset, byte_count, last, total_bytes, status);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    bit ok;
    logic [15:0] cl;
    logic [31:0] flen, start, req;
    int r;

    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; func = 1'b0; fat_index = '0; fat_value = '0; first_cluster = '0;
    file_length = '0; start_byte = '0; request_bytes = '0;
    geo_part = 0; geo_res = 1; geo_copies = 2; geo_spf = 1; geo_root = 512; geo_cs = 4;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset geometry: first sector of cluster 2 is 35.
    rows.push_back(wr_row(16'd2, 16'd3));
    rows.push_back(wr_row(16'd3, 16'd4));
    rows.push_back(wr_row(16'd4, 16'hFFFF));
    rows.push_back(rd_row(16'd2, 5000, 6000, 10, 1, make_cmd(0, 0, 0, 1, 0, ST_PAST_END)));
    rows.push_back(rd_row(16'd2, 10000, 8192, 100, 1, make_cmd(0, 0, 0, 1, 0, ST_CHAIN_END)));
    rows.push_back(rd_row(16'd2, 5000, 0, 0, 1, make_cmd(35, 0, 0, 1, 0, ST_OK)));
    rows.push_back(rd_row(16'd2, 5000, 0, 0, 0, make_cmd(0, 0, 0, 0, 0, 0)));
    rows.push_back(rd_row(16'd2, 32'hFFFFFFFF, 100, 32'hFFFFFFFF, 0,
                          make_cmd(0, 0, 0, 0, 0, 0)));
    rows.push_back(rd_row(16'd2, 3000, 2047, 2, 0, make_cmd(0, 0, 0, 0, 0, 0)));
    rows.push_back(rd_row(16'd3, 0, 0, 5, 1, make_cmd(0, 0, 0, 1, 0, ST_PAST_END)));
    rows.push_back(wr_row(16'd0, 16'd1));
    rows.push_back(wr_row(16'd1, CHAIN_END));
    rows.push_back(rd_row(16'd0, 100, 0, 100, 1, make_cmd(27, 0, 100, 1, 100, ST_OK)));
    rows.push_back(rd_row(16'd1, 100, 0, 100, 0, make_cmd(0, 0, 0, 0, 0, 0)));
    rows.push_back(wr_row(16'hFFFF, 16'hFFF8));
    rows.push_back(rd_row(16'hFFFF, 10, 0, 10, 0, make_cmd(0, 0, 0, 0, 0, 0)));
    rows.push_back(wr_row(16'd5, 16'd0));
    rows.push_back(wr_row(16'd200, 16'd200));
    rows.push_back(rd_row(16'd200, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0,
                          make_cmd(0, 0, 0, 0, 0, 0)));
    rows.push_back(rd_row(16'd200, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1,
                          make_cmd(0, 0, 0, 1, 0, ST_PAST_END)));
    foreach (rows[i]) begin
      if (rows[i].func == 1'b0)
        send_item(1'b0, rows[i].idx, rows[i].val, 16'($urandom), $urandom, $urandom, $urandom);
      else
        issue_read(rows[i].cl, rows[i].flen, rows[i].start, rows[i].req,
                   rows[i].typed, rows[i].exp, ok);
    end

    // Random phases, each under its own volume geometry.
    for (int ph = 1; ph <= 5; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(REG_PART_START, 32'hFFFFFFFF);
          write_reg(REG_RESERVED, 32'd65535);
          write_reg(REG_FAT_COPIES, 32'd4);
          write_reg(REG_SECT_PER_FAT, 32'd65535);
          write_reg(REG_ROOT_ENTRIES, 32'd65535);
          write_reg(REG_CLUSTER_SECT, 32'd64);
        end
        2: begin
          write_reg(REG_PART_START, 32'd0);
          write_reg(REG_RESERVED, 32'd0);
          write_reg(REG_FAT_COPIES, 32'd1);
          write_reg(REG_SECT_PER_FAT, 32'd1);
          write_reg(REG_ROOT_ENTRIES, 32'd0);
          write_reg(REG_CLUSTER_SECT, 32'd1);
        end
        3: write_reg(REG_CLUSTER_SECT, 32'd0);
        4: write_reg(REG_CLUSTER_SECT, 32'd127);
        default: begin
          write_reg(REG_PART_START, $urandom);
          write_reg(REG_RESERVED, $urandom_range(0, 65535));
          write_reg(REG_FAT_COPIES, $urandom_range(1, 4));
          write_reg(REG_SECT_PER_FAT, $urandom_range(1, 65535));
          write_reg(REG_ROOT_ENTRIES, $urandom_range(0, 65535));
          write_reg(REG_CLUSTER_SECT, $urandom_range(1, 64));
        end
      endcase
      for (int n = 0; n < 16; n++) begin
        if (ph == 5 && n >= 6) calm = 1;
        if ($urandom_range(0, 99) < 15) begin
          send_item(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom,
                    $urandom);
        end else begin
          ok = 0;
          while (!ok) begin
            cl = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(2, 40)) : 16'($urandom);
            flen = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200000) : $urandom;
            r = $urandom_range(0, 99);
            if (r < 50) start = $urandom_range(0, 20000);
            else if (r < 75) start = $urandom;
            else start = flen;
            r = $urandom_range(0, 99);
            if (r < 40) req = $urandom_range(0, 10000);
            else if (r < 70) req = $urandom;
            else req = 32'hFFFFFFFF;
            issue_read(cl, flen, start, req, 0, make_cmd(0, 0, 0, 0, 0, 0), ok);
          end
        end
      end
    end

    drain();
    if (mismatches == 0 && expected_cmds.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
